/* rtl/assert_macros.svh */
// assertion macros shared by the angle tracker rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/mfat_pkg.sv */
// shared types and constants of the motor feedback angle tracker
// used by every rtl module of the block, no dependencies
package mfat_pkg;

  localparam int ID_W    = 11;
  localparam int IDX_W   = 4;
  localparam int ANGLE_W = 16;
  localparam int WORD_W  = 16;
  localparam int AUX_W   = 8;
  localparam int TOTAL_W = 32;
  localparam int COUNT_W = 32;

  // first motor identifier after reset
  localparam logic [ID_W-1:0] FIRST_ID_RESET = 11'd513;

  // depth of the queue between classifier and update unit
  localparam int QUEUE_DEPTH = 2;

  // one classified frame on its way to the table update
  typedef struct packed {
    logic                     bus;
    logic [IDX_W-1:0]         idx;
    logic [ANGLE_W-1:0]       angle;
    logic signed [WORD_W-1:0] speed;
    logic signed [WORD_W-1:0] current;
    logic [AUX_W-1:0]         aux;
  } item_t;

endpackage

/* rtl/motor_feedback_angle_tracker.sv */
// motor feedback angle tracker: multi-turn encoder unwrap per bus and motor
// top level, instantiates mfat_front, mfat_queue, mfat_back; uses mfat_pkg
//
// usage:
//   in_*  : one received motor feedback frame per transaction; in_tuser holds
//           the bus, in_tdata the identifier and decoded payload words
//   out_* : one result per frame whose identifier lies in the motor window
//           first_motor_id .. first_motor_id + MOTORS_PER_BUS - 1; frames
//           outside the window are taken and give no result
//   cfg_* : write of first_motor_id, only while the block is idle
// path: a taken frame goes through the queue and the table update into the result register
// throughput: one frame per cycle while out_tready is high, set by the
//   read-modify-write of the motor table in the update unit
// reset: first_motor_id returns to 513, all motor entries read as zero
//   (per-entry valid bits clear at once, no clearing pass)
// stall: the result register holds while out_tready is low, the two-entry
//   queue takes up to two more frames, then in_tready drops
module motor_feedback_angle_tracker #(
  parameter int MOTORS_PER_BUS  = 11,
  parameter int BUS_COUNT       = 2,
  parameter int COUNTS_PER_TURN = 8192
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,   // first_motor_id
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic         in_tuser,      // bus_select
  // frame_id[10:0], angle_word[26:11], speed_word[42:27],
  // current_word[58:43], aux_byte[66:59], zero[71:67]
  input  logic [71:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic         out_tuser,     // motor_bus
  // motor_index[3:0], angle_now[19:4], speed_now[35:20], current_now[51:36],
  // aux_now[59:52], angle_total[91:60], frame_count[123:92], zero[127:124]
  output logic [127:0] out_tdata
);

  logic                          push_valid;
  logic                          push_ready;
  mfat_pkg::item_t               push_item;
  logic                          pop_valid;
  logic                          pop_ready;
  mfat_pkg::item_t               pop_item;
  mfat_pkg::item_t               res_item;
  logic [mfat_pkg::TOTAL_W-1:0]  res_total;
  logic [mfat_pkg::COUNT_W-1:0]  res_count;

  // classifier
  mfat_front #(
    .MOTORS_PER_BUS (MOTORS_PER_BUS),
    .BUS_COUNT      (BUS_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_bus     (in_tuser),
    .in_id      (in_tdata[10:0]),
    .in_angle   (in_tdata[26:11]),
    .in_speed   (in_tdata[42:27]),
    .in_current (in_tdata[58:43]),
    .in_aux     (in_tdata[66:59]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  mfat_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  // table update and result register
  mfat_back #(
    .MOTORS_PER_BUS (MOTORS_PER_BUS),
    .BUS_COUNT      (BUS_COUNT),
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_item (pop_item),
    .res_valid(out_tvalid),
    .res_ready(out_tready),
    .res_item (res_item),
    .res_total(res_total),
    .res_count(res_count)
  );

  // result packing
  assign out_tuser = res_item.bus;
  assign out_tdata = {4'b0, res_count, res_total, res_item.aux, res_item.current,
                      res_item.speed, res_item.angle, res_item.idx};

endmodule

/* rtl/mfat_front.sv */
// frame classifier: holds the first motor id register, filters the id window
// depends on mfat_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfat_front #(
  parameter int MOTORS_PER_BUS = 11,
  parameter int BUS_COUNT      = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [mfat_pkg::ID_W-1:0]      cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_bus,
  input  logic [mfat_pkg::ID_W-1:0]      in_id,
  input  logic [mfat_pkg::ANGLE_W-1:0]   in_angle,
  input  logic [mfat_pkg::WORD_W-1:0]    in_speed,
  input  logic [mfat_pkg::WORD_W-1:0]    in_current,
  input  logic [mfat_pkg::AUX_W-1:0]     in_aux,
  output logic                           push_valid,
  input  logic                           push_ready,
  output mfat_pkg::item_t                push_item
);

  logic [mfat_pkg::ID_W-1:0] first_id_r;
  logic [mfat_pkg::ID_W-1:0] first_id_nxt;
  logic [mfat_pkg::ID_W-1:0] id_diff;
  logic                      in_window;
  logic                      bus_cl;

  // first motor id register
  always_comb begin
    first_id_nxt = first_id_r;
    if (cfg_wr_en) begin
      first_id_nxt = cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_id_r <= mfat_pkg::FIRST_ID_RESET;
    end else begin
      first_id_r <= first_id_nxt;
    end
  end

  // id window check
  assign id_diff   = in_id - first_id_r;
  assign in_window = (in_id >= first_id_r) &&
                     (id_diff < mfat_pkg::ID_W'(MOTORS_PER_BUS));

  // out-of-range bus maps onto the last bus
  assign bus_cl = (BUS_COUNT <= 1) ? 1'b0 :
                  ((int'(in_bus) >= BUS_COUNT) ? 1'(BUS_COUNT - 1) : in_bus);

  // frames outside the window are taken and dropped
  assign in_ready   = push_ready;
  assign push_valid = in_valid && in_window;

  always_comb begin
    push_item         = '0;
    push_item.bus     = bus_cl;
    push_item.idx     = mfat_pkg::IDX_W'(id_diff);
    push_item.angle   = in_angle;
    push_item.speed   = in_speed;
    push_item.current = in_current;
    push_item.aux     = in_aux;
  end

  `ASSERT_IMPLIES(a_push_in_window, push_valid,
                  int'(push_item.idx) < MOTORS_PER_BUS)

endmodule

/* rtl/mfat_queue.sv */
// short queue of classified frames between classifier and update unit
// depends on mfat_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfat_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mfat_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output mfat_pkg::item_t pop_item
);

  localparam int DEPTH = mfat_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mfat_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r < CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_push_grows, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

/* rtl/mfat_back.sv */
// table update: per-motor angle unwrap, total and frame count, result register
// depends on mfat_pkg and assert_macros.svh
`include "assert_macros.svh"

module mfat_back #(
  parameter int MOTORS_PER_BUS  = 11,
  parameter int BUS_COUNT       = 2,
  parameter int COUNTS_PER_TURN = 8192
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  mfat_pkg::item_t                 pop_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output mfat_pkg::item_t                 res_item,
  output logic [mfat_pkg::TOTAL_W-1:0]    res_total,
  output logic [mfat_pkg::COUNT_W-1:0]    res_count
);

  localparam int ENTRIES = BUS_COUNT * MOTORS_PER_BUS;
  localparam int ENT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DIFF_W  = mfat_pkg::ANGLE_W + 3;
  localparam logic signed [DIFF_W-1:0] TURN = DIFF_W'(COUNTS_PER_TURN);

  // per-entry state, a clear valid bit reads as zero
  logic [ENTRIES-1:0]               valid_r;
  logic [mfat_pkg::ANGLE_W-1:0]     prev_r  [ENTRIES];
  logic [mfat_pkg::TOTAL_W-1:0]     total_r [ENTRIES];
  logic [mfat_pkg::COUNT_W-1:0]     cnt_r   [ENTRIES];

  logic                             out_valid_r, out_valid_nxt;
  mfat_pkg::item_t                  out_item_r;
  logic [mfat_pkg::TOTAL_W-1:0]     out_total_r;
  logic [mfat_pkg::COUNT_W-1:0]     out_count_r;

  logic                             fire;
  logic [ENT_W-1:0]                 entry;
  logic [mfat_pkg::ANGLE_W-1:0]     prev_rd;
  logic [mfat_pkg::TOTAL_W-1:0]     total_rd;
  logic [mfat_pkg::COUNT_W-1:0]     cnt_rd;
  logic signed [DIFF_W-1:0]         a_s, p_s, direct, other, mag_d, mag_o, step;
  logic [mfat_pkg::TOTAL_W-1:0]     total_new;
  logic [mfat_pkg::COUNT_W-1:0]     cnt_new;

  assign pop_ready = !out_valid_r || res_ready;
  assign fire      = pop_valid && pop_ready;

  // entry address and table read
  assign entry    = ENT_W'(int'(pop_item.bus) * MOTORS_PER_BUS) + ENT_W'(pop_item.idx);
  assign prev_rd  = valid_r[entry] ? prev_r[entry]  : '0;
  assign total_rd = valid_r[entry] ? total_r[entry] : '0;
  assign cnt_rd   = valid_r[entry] ? cnt_r[entry]   : '0;

  // unwrap: pick the smaller of direct and turn-corrected difference
  always_comb begin
    a_s    = signed'(DIFF_W'(pop_item.angle));
    p_s    = signed'(DIFF_W'(prev_rd));
    direct = a_s - p_s;
    other  = (pop_item.angle < prev_rd) ? direct + TURN : direct - TURN;
    mag_d  = (direct < 0) ? -direct : direct;
    mag_o  = (other < 0) ? -other : other;
    step   = (mag_o < mag_d) ? other : direct;
  end

  assign total_new = total_rd + mfat_pkg::TOTAL_W'(step);
  assign cnt_new   = cnt_rd + 1'b1;

  // table write
  always_ff @(posedge clk) begin
    if (fire) begin
      prev_r[entry]  <= pop_item.angle;
      total_r[entry] <= total_new;
      cnt_r[entry]   <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (fire) begin
      valid_r[entry] <= 1'b1;
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r  <= pop_item;
      out_total_r <= total_new;
      out_count_r <= cnt_new;
    end
  end

  assign res_valid = out_valid_r;
  assign res_item  = out_item_r;
  assign res_total = out_total_r;
  assign res_count = out_count_r;

  `ASSERT_NEXT(a_fire_loads, fire,
               out_valid_r && (out_count_r == $past(cnt_rd) + 1'b1))

endmodule
